[hdl/lobm_pkg.sv]
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types and codes of the limit order book matcher: input and result
// words, operation codes and status codes.
// ----------------------------------------------------------------------------
package lobm_pkg;

  localparam int ORDER_SLOTS_DEF  = 64;
  localparam int PRICE_LEVELS_DEF = 1024;
  localparam int ID_BITS_DEF      = 32;

  localparam int PRICE_W = 10;
  localparam int QTY_W   = 20;
  localparam int TIME_W  = 48;
  localparam int OID_W   = 32;

  typedef enum logic [1:0] {
    OP_LIMIT  = 2'd0,
    OP_IOC    = 2'd1,
    OP_CANCEL = 2'd2,
    OP_MODIFY = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_RESTED       = 3'd0,
    ST_LIMIT_FILLED = 3'd1,
    ST_IOC_FILLED   = 3'd2,
    ST_IOC_DONE     = 3'd3,
    ST_CANCELLED    = 3'd4,
    ST_NOT_FOUND    = 3'd5,
    ST_MODIFIED     = 3'd6,
    ST_POOL_FULL    = 3'd7
  } status_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic               is_buy;
    logic [PRICE_W-1:0] price_tick;
    logic [QTY_W-1:0]   quantity;
    logic [TIME_W-1:0]  timestamp;
    logic [OID_W-1:0]   target_id;
  } order_t;

  typedef struct packed {
    logic               is_trade;
    logic [OID_W-1:0]   buyer_id;
    logic [OID_W-1:0]   seller_id;
    logic [PRICE_W-1:0] trade_price;
    logic [QTY_W-1:0]   trade_quantity;
    logic [TIME_W-1:0]  trade_time;
    logic [OID_W-1:0]   rested_id;
    logic [2:0]         status;
    logic               last_result;
  } result_t;

endpackage

[hdl/limit_order_book_matcher.sv]
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority order book. Resting orders live in one slot memory as
// doubly linked lists per price level, with head and tail marks per slot.
//
//   channel  dir  handshake             word
//   order    in   order_valid/stall     lobm_pkg::order_t
//   result   out  result_valid/stall    lobm_pkg::result_t
//
// one input at a time: order_stall stays high until the final word is loaded.
// every fill takes a full pass over the slot memory to find the best opposite
// head, then a drained order is unlinked via S_UP_RD, S_UN_RD and S_UL_DONE,
// plus S_UP_WR/S_UN_WR where it has neighbours; cancel/modify take one pass
// to find the id, a resting remainder one more pass, then S_REST_WR/S_RT_WR.
// no clearing pass after reset: only the per-slot used bits are cleared.
// a stalled result holds the engine only when a new result must be loaded.
// ----------------------------------------------------------------------------
module limit_order_book_matcher #(
  parameter int ORDER_SLOTS  = lobm_pkg::ORDER_SLOTS_DEF,
  parameter int PRICE_LEVELS = lobm_pkg::PRICE_LEVELS_DEF,
  parameter int ID_BITS      = lobm_pkg::ID_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              order_valid,
  output logic              order_stall,
  input  lobm_pkg::order_t  order,
  output logic              result_valid,
  input  logic              result_stall,
  output lobm_pkg::result_t result
);
  import lobm_pkg::*;

  localparam int SLOT_W = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int CW     = (ID_BITS > OID_W) ? ID_BITS : OID_W;
  localparam int PMAX   = (PRICE_LEVELS > 1024) ? 1023 : PRICE_LEVELS - 1;
  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(ORDER_SLOTS - 1);

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [SLOT_W-1:0]  nxt;
    logic [SLOT_W-1:0]  prv;
    logic               head;
    logic               tail;
  } slot_t;

  typedef enum logic [1:0] {K_BEST, K_FIND, K_REST} kind_t;
  typedef enum logic [1:0] {R_MATCH, R_CANCEL, R_READD} ret_t;
  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_WAIT, S_END, S_FILL, S_UP_RD, S_UP_WR, S_UN_RD, S_UN_WR,
    S_UL_DONE, S_REST_WR, S_RT_RD, S_RT_WR, S_FINISH
  } state_t;

  slot_t mem [ORDER_SLOTS];
  slot_t rdata, wdata;
  logic [SLOT_W-1:0] raddr, waddr;
  logic mem_we;

  state_t state;
  kind_t kind;
  ret_t ret;
  logic [ORDER_SLOTS-1:0] used;
  logic [ID_BITS-1:0] id_cnt, my_id;

  // current input
  logic [1:0] op;
  logic side, limited, is_mod;
  logic [PRICE_W-1:0] price;
  logic [QTY_W-1:0] qty;
  logic [TIME_W-1:0] tstamp;
  logic [OID_W-1:0] oid;
  logic [OID_W-1:0] newid;
  status_t st;

  // scan
  logic [SLOT_W-1:0] scan_idx, chk_idx;
  logic chk_on;
  logic hit_f, free_f;
  logic [SLOT_W-1:0] hit_i, free_i;
  slot_t hit_e;

  // unlink
  slot_t ue;
  logic [SLOT_W-1:0] ui;

  result_t pend;
  logic pend_valid;

  logic can_load, fill_go, drained;
  logic [QTY_W-1:0] m;
  logic [PRICE_W-1:0] in_price;
  result_t trade;
  logic res_load;
  result_t res_word;

  assign order_stall = (state != S_IDLE);
  assign can_load = !result_valid || !result_stall;
  assign fill_go = !pend_valid || can_load;
  assign m = (qty < hit_e.qty) ? qty : hit_e.qty;
  assign drained = (hit_e.qty == m);
  assign in_price = (int'(order.price_tick) > PMAX) ? PRICE_W'(PMAX) : order.price_tick;
  assign res_load = ((state == S_FILL) && fill_go && pend_valid) ||
                    ((state == S_FINISH) && can_load);

  always_comb begin
    trade = '0;
    trade.is_trade = 1'b1;
    trade.buyer_id = side ? OID_W'(my_id) : OID_W'(hit_e.id);
    trade.seller_id = side ? OID_W'(hit_e.id) : OID_W'(my_id);
    trade.trade_price = hit_e.price;
    trade.trade_quantity = m;
    trade.trade_time = tstamp;
  end

  // word for the output register: a buffered trade, or the final word
  always_comb begin
    res_word = pend;
    if (state == S_FINISH) begin
      if (!pend_valid) res_word = '0;
      res_word.rested_id = newid;
      res_word.status = st;
      res_word.last_result = 1'b1;
    end
  end

  always_comb begin
    raddr = scan_idx;
    waddr = hit_i;
    wdata = hit_e;
    mem_we = 1'b0;
    case (state)
      S_UP_RD: raddr = ue.prv;
      S_UN_RD: raddr = ue.nxt;
      S_RT_RD: raddr = hit_i;
      S_FILL: begin
        wdata.qty = hit_e.qty - m;
        mem_we = fill_go && !drained;
      end
      S_END: begin
        // in-place modify to a lower quantity
        wdata.qty = qty;
        mem_we = (kind == K_FIND) && hit_f && (op == OP_MODIFY) && (qty != '0)
                 && (qty < hit_e.qty);
      end
      S_UP_WR: begin
        waddr = ue.prv;
        wdata = rdata;
        wdata.nxt = ue.nxt;
        if (ue.tail) wdata.tail = 1'b1;
        mem_we = 1'b1;
      end
      S_UN_WR: begin
        waddr = ue.nxt;
        wdata = rdata;
        wdata.prv = ue.prv;
        if (ue.head) wdata.head = 1'b1;
        mem_we = 1'b1;
      end
      S_REST_WR: begin
        waddr = free_i;
        wdata.id = my_id;
        wdata.side = side;
        wdata.price = price;
        wdata.qty = qty;
        wdata.nxt = '0;
        wdata.prv = hit_i;
        wdata.head = !hit_f;
        wdata.tail = 1'b1;
        mem_we = free_f;
      end
      S_RT_WR: begin
        waddr = hit_i;
        wdata = rdata;
        wdata.nxt = free_i;
        wdata.tail = 1'b0;
        mem_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
      id_cnt <= ID_BITS'(1);
      pend_valid <= 1'b0;
      result_valid <= 1'b0;
      chk_on <= 1'b0;
    end else begin
      if (res_load) begin
        result <= res_word;
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      chk_on <= (state == S_SCAN);
      chk_idx <= scan_idx;

      // scan compare on the word read last cycle
      if (chk_on) begin
        case (kind)
          K_BEST: begin
            if (used[chk_idx] && rdata.side == !side && rdata.head &&
                (!hit_f || (side ? rdata.price < hit_e.price
                                 : rdata.price > hit_e.price))) begin
              hit_f <= 1'b1;
              hit_i <= chk_idx;
              hit_e <= rdata;
            end
          end
          K_FIND: begin
            if (used[chk_idx] && !hit_f && CW'(rdata.id) == CW'(oid)) begin
              hit_f <= 1'b1;
              hit_i <= chk_idx;
              hit_e <= rdata;
            end
          end
          K_REST: begin
            if (!used[chk_idx] && !free_f) begin
              free_f <= 1'b1;
              free_i <= chk_idx;
            end
            if (used[chk_idx] && rdata.side == side && rdata.price == price &&
                rdata.tail) begin
              hit_f <= 1'b1;
              hit_i <= chk_idx;
            end
          end
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (order_valid) begin
            op <= order.opcode;
            side <= order.is_buy;
            price <= in_price;
            qty <= order.quantity;
            tstamp <= order.timestamp;
            oid <= order.target_id;
            newid <= '0;
            is_mod <= 1'b0;
            limited <= (order.opcode == OP_LIMIT);
            scan_idx <= '0;
            hit_f <= 1'b0;
            free_f <= 1'b0;
            state <= S_SCAN;
            if (order.opcode == OP_LIMIT || order.opcode == OP_IOC) begin
              my_id <= id_cnt;
              id_cnt <= id_cnt + 1'b1;
              kind <= K_BEST;
            end else begin
              kind <= K_FIND;
            end
          end
        end
        S_SCAN: begin
          if (scan_idx == LAST) state <= S_WAIT;
          else scan_idx <= scan_idx + 1'b1;
        end
        S_WAIT: state <= S_END;
        S_END: begin
          scan_idx <= '0;
          case (kind)
            K_BEST: begin
              if (!hit_f || (limited && (side ? price < hit_e.price
                                              : price > hit_e.price))) begin
                if (limited) begin
                  kind <= K_REST;
                  hit_f <= 1'b0;
                  free_f <= 1'b0;
                  state <= S_SCAN;
                end else begin
                  st <= ST_IOC_DONE;
                  state <= S_FINISH;
                end
              end else begin
                state <= S_FILL;
              end
            end
            K_FIND: begin
              ue <= hit_e;
              ui <= hit_i;
              if (!hit_f) begin
                st <= ST_NOT_FOUND;
                state <= S_FINISH;
              end else if (op == OP_CANCEL || qty == '0) begin
                ret <= R_CANCEL;
                state <= S_UP_RD;
              end else if (qty < hit_e.qty) begin
                st <= ST_MODIFIED;
                state <= S_FINISH;
              end else begin
                ret <= R_READD;
                state <= S_UP_RD;
              end
            end
            default: begin
              if (!free_f) begin
                st <= ST_POOL_FULL;
                state <= S_FINISH;
              end else begin
                used[free_i] <= 1'b1;
                newid <= OID_W'(my_id);
                st <= is_mod ? ST_MODIFIED : ST_RESTED;
                state <= S_REST_WR;
              end
            end
          endcase
        end
        S_FILL: begin
          if (fill_go) begin
            pend <= trade;
            pend_valid <= 1'b1;
            qty <= qty - m;
            if (drained) begin
              ue <= hit_e;
              ui <= hit_i;
              ret <= R_MATCH;
              state <= S_UP_RD;
            end else begin
              st <= is_mod ? ST_MODIFIED : (limited ? ST_LIMIT_FILLED : ST_IOC_FILLED);
              state <= S_FINISH;
            end
          end
        end
        S_UP_RD: state <= ue.head ? S_UN_RD : S_UP_WR;
        S_UP_WR: state <= S_UN_RD;
        S_UN_RD: state <= ue.tail ? S_UL_DONE : S_UN_WR;
        S_UN_WR: state <= S_UL_DONE;
        S_UL_DONE: begin
          used[ui] <= 1'b0;
          scan_idx <= '0;
          hit_f <= 1'b0;
          free_f <= 1'b0;
          case (ret)
            R_MATCH: begin
              if (qty == '0) begin
                st <= is_mod ? ST_MODIFIED : (limited ? ST_LIMIT_FILLED : ST_IOC_FILLED);
                state <= S_FINISH;
              end else begin
                kind <= K_BEST;
                state <= S_SCAN;
              end
            end
            R_CANCEL: begin
              st <= ST_CANCELLED;
              state <= S_FINISH;
            end
            default: begin
              // re-add as a fresh limit order on the same side and price
              my_id <= id_cnt;
              id_cnt <= id_cnt + 1'b1;
              side <= ue.side;
              price <= ue.price;
              limited <= 1'b1;
              is_mod <= 1'b1;
              kind <= K_BEST;
              state <= S_SCAN;
            end
          endcase
        end
        S_REST_WR: state <= hit_f ? S_RT_RD : S_FINISH;
        S_RT_RD: state <= S_RT_WR;
        S_RT_WR: state <= S_FINISH;
        S_FINISH: begin
          if (can_load) begin
            pend_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
